FILE: rtl/fwir_pkg.sv
`timescale 1ns / 1ps

package fwir_pkg;

    // Default sizing of the queue
    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W      = 2;
    localparam int PAYLOAD_W = 32;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Wide enough for any occupancy up to the largest depth (256)
    localparam int OCC_MAX_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_PEEK    = 2'd2
    } t_op;

    // Broadcast from the queue control to every cell
    typedef struct packed {
        logic                 enq;       // append at index occ
        logic                 rem;       // close the gap at pos
        logic [POS_W-1:0]     pos;
        logic [OCC_MAX_W-1:0] occ;
    } t_cell_ctrl;

endpackage

FILE: rtl/fwir_cell.sv
`timescale 1ns / 1ps

module fwir_cell #(
    parameter int WORD_BITS = fwir_pkg::WORD_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                   i_clk,
    input  fwir_pkg::t_cell_ctrl   i_ctrl,
    input  logic [WORD_BITS-1:0]   i_new_word,
    input  logic [WORD_BITS-1:0]   i_next_word,
    output logic [WORD_BITS-1:0]   o_word
);

    localparam logic [fwir_pkg::OCC_MAX_W-1:0] IDX_V  = fwir_pkg::OCC_MAX_W'(IDX);
    localparam logic [fwir_pkg::OCC_MAX_W-1:0] IDX_NX = fwir_pkg::OCC_MAX_W'(IDX + 1);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 load_new;
    logic                 take_next;

    assign load_new  = i_ctrl.enq && (IDX_V == i_ctrl.occ);
    // shift forward when at or past the removed slot and a later word exists
    assign take_next = i_ctrl.rem
                    && (IDX_V >= fwir_pkg::OCC_MAX_W'(i_ctrl.pos))
                    && (IDX_NX < i_ctrl.occ);

    always_comb begin
        n_word = r_word;
        if (load_new) begin
            n_word = i_new_word;
        end else if (take_next) begin
            n_word = i_next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/fifo_with_indexed_remove_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields in tdata (lowest bit first)
// s_axis    in   operation[1:0] payload[33:2] position[37:34] zero[39:38]
// m_axis    out  word_out[31:0] found[32] rejected[33] count_after[38:34] zero[39]
//
// One request per cycle: the row of cells updates in the accept cycle and the
// result lands in a single output register, so s_axis_tready stays high while
// that register is empty or being taken in the same cycle.
// A stalled m_axis holds the result and blocks new requests until it drains.
// Reset (i_rst_n low, synchronous) empties the queue; slot words are not cleared.

module fifo_with_indexed_remove_core #(
    parameter int DEPTH     = fwir_pkg::DEPTH_DEF,
    parameter int WORD_BITS = fwir_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation, payload, position, zero fill
    input  logic [fwir_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // word_out, found, rejected, count_after, zero fill
    output logic [fwir_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int RD_N  = (DEPTH < (1 << fwir_pkg::POS_W)) ? DEPTH : (1 << fwir_pkg::POS_W);
    localparam int PW    = fwir_pkg::PAYLOAD_W;
    localparam int MW    = fwir_pkg::OCC_MAX_W;

    logic                          s_fire;
    fwir_pkg::t_op                 op;
    logic [PW-1:0]                 in_payload;
    logic [fwir_pkg::POS_W-1:0]    in_pos;
    logic [WORD_BITS-1:0]          new_word;
    logic [WORD_BITS-1:0]          rd_word;
    logic [PW-1:0]                 rd_word_out;
    logic                          pos_ok;
    logic                          enq_ok;
    logic                          rem_ok;
    logic                          hit;
    logic                          full_rej;
    fwir_pkg::t_cell_ctrl          ctrl;
    logic [WORD_BITS-1:0]          cell_q [DEPTH];

    logic [OCC_W-1:0]              r_occ;
    logic [OCC_W-1:0]              n_occ;
    logic                          r_out_valid;
    logic [PW-1:0]                 r_word;
    logic                          r_found;
    logic                          r_rej;
    logic [fwir_pkg::COUNT_W-1:0]  r_count;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign op         = fwir_pkg::t_op'(s_axis_tdata[fwir_pkg::OP_W-1:0]);
    assign in_payload = s_axis_tdata[fwir_pkg::OP_W +: PW];
    assign in_pos     = s_axis_tdata[fwir_pkg::OP_W + PW +: fwir_pkg::POS_W];

    generate
        if (WORD_BITS >= PW) begin : g_wide
            assign new_word    = WORD_BITS'(in_payload);
            assign rd_word_out = rd_word[PW-1:0];
        end else begin : g_narrow
            assign new_word    = in_payload[WORD_BITS-1:0];
            assign rd_word_out = PW'(rd_word);
        end
    endgenerate

    assign pos_ok   = MW'(in_pos) < MW'(r_occ);
    assign enq_ok   = s_fire && (op == fwir_pkg::OP_ENQUEUE) && (r_occ != OCC_W'(DEPTH));
    assign full_rej = (op == fwir_pkg::OP_ENQUEUE) && (r_occ == OCC_W'(DEPTH));
    assign rem_ok   = s_fire && (op == fwir_pkg::OP_REMOVE) && pos_ok;
    assign hit      = ((op == fwir_pkg::OP_REMOVE) || (op == fwir_pkg::OP_PEEK)) && pos_ok;

    assign ctrl.enq = enq_ok;
    assign ctrl.rem = rem_ok;
    assign ctrl.pos = in_pos;
    assign ctrl.occ = MW'(r_occ);

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_BITS-1:0] next_w;
            if (gi == DEPTH - 1) begin : g_tail
                assign next_w = '0;
            end else begin : g_mid
                assign next_w = cell_q[gi + 1];
            end
            fwir_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX       (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_new_word  (new_word),
                .i_next_word (next_w),
                .o_word      (cell_q[gi])
            );
        end
    endgenerate

    // position reaches only the first few cells
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (fwir_pkg::POS_W'(i) == in_pos) begin
                rd_word = cell_q[i];
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (enq_ok) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (rem_ok) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (s_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_word  <= hit ? rd_word_out : '0;
            r_found <= hit;
            r_rej   <= full_rej;
            r_count <= fwir_pkg::COUNT_W'(n_occ);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_count, r_rej, r_found, r_word};

endmodule

FILE: rtl/fwir_checker.sv
`timescale 1ns / 1ps

module fwir_checker #(
    parameter int DEPTH = fwir_pkg::DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [fwir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // every accepted request shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no result after accepted request");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_found_xor_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
        else $error("found and rejected both set");

    a_word_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero word without a hit");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((DEPTH > 31) || (int'(m_axis_tdata[38:34]) <= DEPTH)))
        else $error("count beyond depth");

endmodule

bind fifo_with_indexed_remove_core fwir_checker #(
    .DEPTH (DEPTH)
) u_fwir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/fifo_with_indexed_remove_core_tb.sv
`timescale 1ns / 1ps

module fifo_with_indexed_remove_core_tb;

    localparam int             RESET_CYCLES   = 12;
    localparam int             WATCHDOG_LIMIT = 4000;
    localparam int             RANDOM_ITEMS   = 550;
    localparam logic [fwir_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [fwir_pkg::PAYLOAD_W-1:0] word;
        logic                           found;
        logic                           rejected;
        logic [fwir_pkg::COUNT_W-1:0]   count;
    } t_queue_result;

    // Mirror of the collapsing queue plus the results still owed by the block
    class t_queue_tracker;
        logic [fwir_pkg::PAYLOAD_W-1:0] stored [fwir_pkg::DEPTH_DEF];
        int                             fill;
        int                             errors;
        t_queue_result                  owed_results [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void apply_request(logic [fwir_pkg::OP_W-1:0] op,
                                    logic [fwir_pkg::PAYLOAD_W-1:0] payload,
                                    logic [fwir_pkg::POS_W-1:0] pos);
            t_queue_result r;
            int            i;
            r = '0;
            case (op)
                fwir_pkg::OP_ENQUEUE: begin
                    if (fill >= fwir_pkg::DEPTH_DEF) begin
                        r.rejected = 1'b1;
                    end else begin
                        stored[fill] = payload;
                        fill++;
                    end
                end
                fwir_pkg::OP_REMOVE: begin
                    if (pos < fill) begin
                        r.word  = stored[pos];
                        r.found = 1'b1;
                        // close the gap behind the removed word
                        for (i = pos; i + 1 < fill; i++)
                            stored[i] = stored[i + 1];
                        fill--;
                    end
                end
                fwir_pkg::OP_PEEK: begin
                    if (pos < fill) begin
                        r.word  = stored[pos];
                        r.found = 1'b1;
                    end
                end
                default: ;
            endcase
            r.count = fill[fwir_pkg::COUNT_W-1:0];
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [fwir_pkg::OUT_TDATA_W-1:0] tdata);
            t_queue_result want;
            t_queue_result got;
            got.word     = tdata[31:0];
            got.found    = tdata[32];
            got.rejected = tdata[33];
            got.count    = tdata[38:34];
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, tdata);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got.word !== want.word) begin
                $display("%0t: word_out expected %h actual %h", $time, want.word, got.word);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                errors++;
            end
            if (got.rejected !== want.rejected) begin
                $display("%0t: rejected expected %b actual %b", $time, want.rejected,
                         got.rejected);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count_after expected %0d actual %0d", $time, want.count,
                         got.count);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // operation[1:0] payload[33:2] position[37:34] zero[39:38]
    logic [fwir_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // word_out[31:0] found[32] rejected[33] count_after[38:34] zero[39]
    logic [fwir_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    t_queue_tracker tracker = new();
    int             burst_left;
    int             idle_cycles;
    int             stall_mode;
    int             stall_timer;
    int             stall_phase;

    fifo_with_indexed_remove_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Sample both handshakes on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                tracker.apply_request(s_axis_tdata[1:0], s_axis_tdata[33:2],
                                      s_axis_tdata[37:34]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: switch between free flow, coin flips, long periodic stalls and rare stalls
    always @(negedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end
        stall_timer--;
        stall_phase = (stall_phase + 1) % 6;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= (stall_phase == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_request(input logic [fwir_pkg::OP_W-1:0] op,
                                input logic [fwir_pkg::PAYLOAD_W-1:0] payload,
                                input logic [fwir_pkg::POS_W-1:0] pos);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, pos, payload, op};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    function automatic logic [fwir_pkg::PAYLOAD_W-1:0] pick_payload();
        int k;
        k = $urandom_range(0, fwir_pkg::PAYLOAD_W - 1);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << k;
            3:       return ~(32'd1 << k);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [fwir_pkg::POS_W-1:0] pick_position();
        if (tracker.fill > 0 && $urandom_range(0, 4) != 0)
            return fwir_pkg::POS_W'($urandom_range(0, tracker.fill - 1));
        return fwir_pkg::POS_W'($urandom_range(0, 15));
    endfunction

    // Bias the mix by phase so the queue both fills up and drains down
    function automatic logic [fwir_pkg::OP_W-1:0] pick_op(int phase);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_UNUSED;
        case (phase)
            0:       return (roll < 75) ? fwir_pkg::OP_ENQUEUE :
                            (roll < 88) ? fwir_pkg::OP_REMOVE : fwir_pkg::OP_PEEK;
            1:       return (roll < 20) ? fwir_pkg::OP_ENQUEUE :
                            (roll < 85) ? fwir_pkg::OP_REMOVE : fwir_pkg::OP_PEEK;
            2:       return (roll < 40) ? fwir_pkg::OP_ENQUEUE :
                            (roll < 75) ? fwir_pkg::OP_REMOVE : fwir_pkg::OP_PEEK;
            default: return (roll < 30) ? fwir_pkg::OP_ENQUEUE :
                            (roll < 45) ? fwir_pkg::OP_REMOVE : fwir_pkg::OP_PEEK;
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        idle_cycles   = 0;
        stall_mode    = 0;
        stall_timer   = 0;
        stall_phase   = 0;
        burst_left    = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: misses and the unused code
        send_request(fwir_pkg::OP_PEEK, 32'h0, 4'd0);
        send_request(fwir_pkg::OP_REMOVE, 32'h0, 4'd15);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 4'd0);
        // fill to full with corner words
        send_request(fwir_pkg::OP_ENQUEUE, 32'h0000_0000, 4'd15);
        send_request(fwir_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 4'd0);
        for (n = 2; n < fwir_pkg::DEPTH_DEF; n++)
            send_request(fwir_pkg::OP_ENQUEUE,
                         (n % 2) ? 32'hA5A5_5A5A + n : 32'h8000_0001 << n, 4'd0);
        send_request(fwir_pkg::OP_ENQUEUE, 32'hDEAD_BEEF, 4'd0);
        send_request(fwir_pkg::OP_PEEK, 32'h0, 4'd15);
        send_request(fwir_pkg::OP_REMOVE, 32'h0, 4'd15);
        send_request(fwir_pkg::OP_REMOVE, 32'h0, 4'd0);
        send_request(fwir_pkg::OP_REMOVE, 32'h0, 4'd7);
        send_request(OP_UNUSED, 32'h0, 4'd3);

        phase = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                phase = $urandom_range(0, 3);
            send_request(pick_op(phase), pick_payload(), pick_position());
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
